/* design/moi_pkg.sv */
// ----------------------------------------------------------------------------
// moi_pkg
// Shared types and constants of the modal oscillator integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package moi_pkg;

   // Number format: signed fixed point, 24 fraction bits
   localparam int VW = 48;
   localparam int FB = 24;

   // Field widths
   localparam int TIME_W = 40;
   localparam int STEP_W = 25;
   localparam int FREQ_W = 40;
   localparam int ZETA_W = 27;
   localparam int MASS_W = 47;
   localparam int SUBS_W = 7;
   localparam int MODE_W = 2;
   localparam int CSR_W  = 47;
   localparam int CSR_IW = 3;

   // Phase of the sine: bits of f*t above this position, 32 bits
   localparam int PH_W   = 32;
   localparam int PH_LSB = 2 * FB - PH_W;

   localparam int MAX_SUBSTEPS = 64;

   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

   localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
   localparam logic signed [VW-1:0] TWO_PI =
      VW'((TWO_PI_Q32 + (64'd1 << (32 - FB - 1))) >> (32 - FB));
   localparam logic signed [VW-1:0] ONE     = VW'(64'd1 << FB);
   localparam logic signed [VW-1:0] HALF    = VW'(64'd1 << (FB - 1));
   localparam logic signed [VW-1:0] QUARTER = VW'(64'd1 << (FB - 2));

   // Quarter-wave sine polynomial, Q30
   localparam logic signed [VW-1:0] Q30_ONE = VW'(64'd1 << 30);
   localparam logic signed [VW-1:0] SINE_C4 = VW'(172272);

   function automatic logic signed [VW-1:0] sine_coef(input logic [1:0] idx);
      logic signed [VW-1:0] c;
      unique case (idx)
         2'd0:    c = VW'(1686629713);
         2'd1:    c = VW'(693598668);
         2'd2:    c = VW'(85569306);
         default: c = VW'(5026995);
      endcase
      return c;
   endfunction

   // Configuration register indexes
   typedef enum logic [CSR_IW-1:0] {
      CSR_SOLVER_MODE    = 3'd0,
      CSR_MODE_FREQUENCY = 3'd1,
      CSR_DAMPING_RATIO  = 3'd2,
      CSR_MODAL_MASS     = 3'd3,
      CSR_EULER_SUBSTEPS = 3'd4
   } csr_index_type;

   // Solver modes
   typedef enum logic [MODE_W-1:0] {
      MODE_EULER   = 2'd0,
      MODE_NEWMARK = 2'd1,
      MODE_SINE    = 2'd2,
      MODE_NONE    = 2'd3
   } solver_mode_type;

   // Operations of the shared arithmetic unit
   typedef enum logic [2:0] {
      FX_MUL,      // Q.F product, rounded, saturated
      FX_MULQ30,   // Q30 product of non-negative values
      FX_MULRAW,   // raw product, phase bits returned
      FX_DIV,      // Q.F quotient, rounded, saturated
      FX_DIVRAW    // integer quotient, truncated
   } fx_op_type;

   typedef struct packed {
      logic      start;
      fx_op_type op;
   } fx_ctrl_type;

   typedef enum logic [1:0] {
      FXS_IDLE,
      FXS_RUN,
      FXS_FIN
   } fx_state_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_W, ST_W2,
      ST_H, ST_K, ST_E1, ST_E2, ST_E3, ST_E4,
      ST_R, ST_R2, ST_HW, ST_HW2, ST_ZW, ST_ZWR, ST_HWW,
      ST_QP, ST_D1, ST_T1, ST_T2, ST_Q,
      ST_PH, ST_Y2, ST_P, ST_S, ST_M,
      ST_OUT
   } seq_state_type;

endpackage

`default_nettype wire

/* design/moi_req_if.sv */
// ----------------------------------------------------------------------------
// moi_req_if
// Input channel: modal force, current time and step length.
// ----------------------------------------------------------------------------
`default_nettype none

interface moi_req_if;
   import moi_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [VW-1:0]     modal_force;
   logic        [TIME_W-1:0] time_now;
   logic        [STEP_W-1:0] step_length;

   modport source (output valid, modal_force, time_now, step_length, input ready);
   modport sink   (input valid, modal_force, time_now, step_length, output ready);
endinterface

`default_nettype wire

/* design/moi_rsp_if.sv */
// ----------------------------------------------------------------------------
// moi_rsp_if
// Result channel: new modal coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

interface moi_rsp_if;
   import moi_pkg::*;

   logic                 valid;
   logic                 ready;
   logic signed [VW-1:0] mode_coefficient;

   modport source (output valid, mode_coefficient, input ready);
   modport sink   (input valid, mode_coefficient, output ready);
endinterface

`default_nettype wire

/* design/modal_oscillator_integrator_top.sv */
// ----------------------------------------------------------------------------
// modal_oscillator_integrator_top
// Advances one damped structural mode by one time step per input word.
// ----------------------------------------------------------------------------
// One input word gives one result word. Every product and quotient goes
// through one shared bit-serial unit. The block takes no new word while a
// step is in work, but does take one while the previous result still waits
// on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module modal_oscillator_integrator_top (
   input  wire                            clock,
   input  wire                            reset,
   moi_req_if.sink                        req_ch,
   moi_rsp_if.source                      rsp_ch,
   input  wire                            csr_write_en,
   input  wire [moi_pkg::CSR_IW-1:0]      csr_index,
   input  wire [moi_pkg::CSR_W-1:0]       csr_wdata
);
   import moi_pkg::*;

   // Configuration registers
   logic [MODE_W-1:0] mode_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [ZETA_W-1:0] zeta_ff;
   logic [MASS_W-1:0] mass_ff;
   logic [SUBS_W-1:0] subs_ff;

   // Step state
   logic signed [VW-1:0] disp_ff, second_ff, force_last_ff, force_before_ff;

   // Captured input word
   logic signed [VW-1:0]     force_ff;
   logic        [TIME_W-1:0] tnow_ff;
   logic        [STEP_W-1:0] dt_ff;

   // Working registers
   logic signed [VW-1:0] w_ff, w2_ff, x_ff, y_ff, t_ff;
   logic signed [VW-1:0] r2_ff, hw2_ff, zwr_ff, a0_ff, ap1_ff, am1_ff;
   logic signed [VW-1:0] res_ff;
   logic [PH_W-1:0]      ph_ff;
   logic [1:0]           cidx_ff;
   logic [SUBS_W-1:0]    sub_ff;

   // Output register
   logic                 rsp_valid_ff;
   logic signed [VW-1:0] rsp_coef_ff;

   seq_state_type        state_ff, state_in;
   logic                 issued_ff, issued_in;
   logic                 uses_unit;
   fx_ctrl_type          fx_ctrl;
   logic signed [VW-1:0] fx_a, fx_b, fx_res;
   logic                 fx_done;

   logic                 accept;
   logic [SUBS_W-1:0]    n_sub;
   logic signed [VW-1:0] freq_s, zeta_s, mass_s, dt_s, yv, qsum;
   logic signed [VW-1:0] s_cl, s_fx;
   logic                 last_sub, out_free;

   function automatic logic signed [VW-1:0] sadd(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
      logic signed [VW:0] s;
      s = {a[VW-1], a} + {b[VW-1], b};
      if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
      return s[VW-1:0];
   endfunction

   function automatic logic signed [VW-1:0] ssub(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
      logic signed [VW:0] s;
      s = {a[VW-1], a} - {b[VW-1], b};
      if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
      return s[VW-1:0];
   endfunction

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign freq_s = VW'(freq_ff);
   assign zeta_s = VW'(zeta_ff);
   assign mass_s = VW'(mass_ff);
   assign dt_s   = VW'(dt_ff);

   // Substep count: zero acts as one, capped at the maximum
   assign n_sub = (subs_ff == '0) ? SUBS_W'(1) :
                  (subs_ff > SUBS_W'(MAX_SUBSTEPS)) ? SUBS_W'(MAX_SUBSTEPS) : subs_ff;
   assign last_sub = sub_ff == n_sub - SUBS_W'(1);

   // Quarter-wave folding of the phase
   assign yv = ph_ff[PH_W-2] ? Q30_ONE - VW'(ph_ff[PH_W-3:0]) : VW'(ph_ff[PH_W-3:0]);

   assign qsum = sadd(sadd(force_ff, sadd(force_last_ff, force_last_ff)), force_before_ff);

   // Sine result to Q.F with its sign
   assign s_cl = (fx_res > Q30_ONE) ? Q30_ONE : (fx_res[VW-1] ? '0 : fx_res);
   assign s_fx = ph_ff[PH_W-1] ? -((s_cl + VW'(1 << (29 - FB))) >>> (30 - FB))
                               :  ((s_cl + VW'(1 << (29 - FB))) >>> (30 - FB));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         freq_ff <= '0;
         zeta_ff <= '0;
         mass_ff <= MASS_W'(1 << FB);
         subs_ff <= SUBS_W'(10);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SOLVER_MODE:    mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_MODE_FREQUENCY: freq_ff <= csr_wdata[FREQ_W-1:0];
            CSR_DAMPING_RATIO:  zeta_ff <= csr_wdata[ZETA_W-1:0];
            CSR_MODAL_MASS:     mass_ff <= csr_wdata[MASS_W-1:0];
            CSR_EULER_SUBSTEPS: subs_ff <= csr_wdata[SUBS_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state and operand selection
   always_comb begin
      state_in  = state_ff;
      uses_unit = 1'b1;
      fx_ctrl.op = FX_MUL;
      fx_a = '0;
      fx_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            uses_unit = 1'b0;
            if (accept) state_in = (mode_ff == MODE_NONE) ? ST_OUT : ST_W;
         end
         ST_W:   begin fx_a = TWO_PI; fx_b = freq_s; end
         ST_W2:  begin fx_a = w_ff;   fx_b = w_ff;   end
         ST_H: begin
            fx_ctrl.op = FX_DIVRAW;
            fx_a = dt_s + VW'(n_sub >> 1);
            fx_b = VW'(n_sub);
         end
         ST_K:   begin fx_a = sadd(zeta_s, zeta_s); fx_b = w_ff; end
         ST_E1:  begin fx_a = w2_ff; fx_b = disp_ff;   end
         ST_E2:  begin fx_a = y_ff;  fx_b = second_ff; end
         ST_E3:  begin fx_a = x_ff;  fx_b = t_ff;      end
         ST_E4:  begin fx_a = x_ff;  fx_b = second_ff; end
         ST_R:   begin fx_ctrl.op = FX_DIV; fx_a = ONE; fx_b = dt_s; end
         ST_R2:  begin fx_a = x_ff;    fx_b = x_ff;  end
         ST_HW:  begin fx_a = HALF;    fx_b = w_ff;  end
         ST_HW2: begin fx_a = y_ff;    fx_b = y_ff;  end
         ST_ZW:  begin fx_a = zeta_s;  fx_b = w_ff;  end
         ST_ZWR: begin fx_a = y_ff;    fx_b = x_ff;  end
         ST_HWW: begin fx_a = HALF;    fx_b = w2_ff; end
         ST_QP:  begin fx_a = QUARTER; fx_b = qsum;  end
         ST_D1:  begin fx_ctrl.op = FX_DIV; fx_a = y_ff; fx_b = mass_s; end
         ST_T1:  begin fx_a = a0_ff;  fx_b = disp_ff;   end
         ST_T2:  begin fx_a = am1_ff; fx_b = second_ff; end
         ST_Q:   begin fx_ctrl.op = FX_DIV; fx_a = y_ff; fx_b = ap1_ff; end
         ST_PH: begin
            fx_ctrl.op = FX_MULRAW;
            fx_a = freq_s;
            fx_b = VW'(tnow_ff);
         end
         ST_Y2:  begin fx_ctrl.op = FX_MULQ30; fx_a = yv;   fx_b = yv;   end
         ST_P:   begin fx_ctrl.op = FX_MULQ30; fx_a = x_ff; fx_b = t_ff; end
         ST_S:   begin fx_ctrl.op = FX_MULQ30; fx_a = yv;   fx_b = t_ff; end
         ST_M:   begin fx_a = mass_s; fx_b = t_ff; end
         ST_OUT: begin
            uses_unit = 1'b0;
            if (out_free) state_in = ST_IDLE;
         end
         default: uses_unit = 1'b0;
      endcase

      // Step advance once the unit answers
      if (uses_unit && fx_done) begin
         unique case (state_ff)
            ST_W:   state_in = ST_W2;
            ST_W2: begin
               unique case (mode_ff)
                  MODE_EULER:   state_in = ST_H;
                  MODE_NEWMARK: state_in = ST_R;
                  default:      state_in = ST_PH;
               endcase
            end
            ST_H:   state_in = ST_K;
            ST_K:   state_in = ST_E1;
            ST_E1:  state_in = ST_E2;
            ST_E2:  state_in = ST_E3;
            ST_E3:  state_in = ST_E4;
            ST_E4:  state_in = last_sub ? ST_OUT : ST_E1;
            ST_R:   state_in = ST_R2;
            ST_R2:  state_in = ST_HW;
            ST_HW:  state_in = ST_HW2;
            ST_HW2: state_in = ST_ZW;
            ST_ZW:  state_in = ST_ZWR;
            ST_ZWR: state_in = ST_HWW;
            ST_HWW: state_in = ST_QP;
            ST_QP:  state_in = ST_D1;
            ST_D1:  state_in = ST_T1;
            ST_T1:  state_in = ST_T2;
            ST_T2:  state_in = ST_Q;
            ST_Q:   state_in = ST_OUT;
            ST_PH:  state_in = ST_Y2;
            ST_Y2:  state_in = ST_P;
            ST_P:   state_in = (cidx_ff == 2'd0) ? ST_S : ST_P;
            ST_S:   state_in = ST_M;
            ST_M:   state_in = ST_OUT;
            default: state_in = ST_IDLE;
         endcase
      end

      fx_ctrl.start = uses_unit && !issued_ff;
      issued_in     = uses_unit && !fx_done && (issued_ff || fx_ctrl.start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   // Shared arithmetic unit
   moi_fxu u_fxu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (fx_ctrl),
      .op_a   (fx_a),
      .op_b   (fx_b),
      .done   (fx_done),
      .result (fx_res)
   );

   // Step state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff         <= '0;
         second_ff       <= '0;
         force_last_ff   <= '0;
         force_before_ff <= '0;
      end else if (fx_done) begin
         case (state_ff)
            ST_E3: second_ff <= sadd(fx_res, second_ff);
            ST_E4: begin
               disp_ff <= sadd(fx_res, disp_ff);
               if (last_sub) begin
                  force_before_ff <= force_last_ff;
                  force_last_ff   <= force_ff;
               end
            end
            ST_Q: begin
               second_ff       <= disp_ff;
               disp_ff         <= fx_res;
               force_before_ff <= force_last_ff;
               force_last_ff   <= force_ff;
            end
            default: ;
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         force_ff <= req_ch.modal_force;
         tnow_ff  <= req_ch.time_now;
         dt_ff    <= req_ch.step_length;
         res_ff   <= '0;
         sub_ff   <= '0;
      end
      if (fx_done) begin
         case (state_ff)
            ST_W:   w_ff  <= fx_res;
            ST_W2:  w2_ff <= fx_res;
            ST_H:   x_ff  <= fx_res;
            ST_K:   y_ff  <= fx_res;
            ST_E1:  t_ff  <= fx_res;
            ST_E2:  t_ff  <= ssub(ssub(force_ff, t_ff), fx_res);
            ST_E4: begin
               sub_ff <= sub_ff + SUBS_W'(1);
               res_ff <= sadd(fx_res, disp_ff);
            end
            ST_R:   x_ff   <= fx_res;
            ST_R2:  r2_ff  <= fx_res;
            ST_HW:  y_ff   <= fx_res;
            ST_HW2: hw2_ff <= fx_res;
            ST_ZW:  y_ff   <= fx_res;
            ST_ZWR: zwr_ff <= fx_res;
            ST_HWW: begin
               a0_ff  <= ssub(fx_res, sadd(r2_ff, r2_ff));
               ap1_ff <= sadd(sadd(r2_ff, zwr_ff), hw2_ff);
               am1_ff <= sadd(ssub(r2_ff, zwr_ff), hw2_ff);
            end
            ST_QP:  y_ff <= fx_res;
            ST_D1:  y_ff <= fx_res;
            ST_T1:  x_ff <= fx_res;
            ST_T2:  y_ff <= ssub(ssub(y_ff, x_ff), fx_res);
            ST_Q:   res_ff <= fx_res;
            ST_PH: begin
               ph_ff   <= fx_res[PH_W-1:0];
               t_ff    <= SINE_C4;
               cidx_ff <= 2'd3;
            end
            ST_Y2:  x_ff <= fx_res;
            ST_P: begin
               t_ff    <= sine_coef(cidx_ff) - fx_res;
               cidx_ff <= cidx_ff - 2'd1;
            end
            ST_S:   t_ff   <= s_fx;
            ST_M:   res_ff <= fx_res;
            default: ;
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) rsp_coef_ff <= res_ff;
   end

   assign req_ch.ready            = state_ff == ST_IDLE;
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.mode_coefficient = rsp_coef_ff;

endmodule

`default_nettype wire

/* design/moi_fxu.sv */
// ----------------------------------------------------------------------------
// moi_fxu
// Shared bit-serial fixed point unit: shift-add multiply (48 steps) and
// restoring divide (72 steps); Q.F and Q30 results are rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module moi_fxu (
   input  wire                        clock,
   input  wire                        reset,
   input  moi_pkg::fx_ctrl_type       ctrl,
   input  wire signed [moi_pkg::VW-1:0] op_a,
   input  wire signed [moi_pkg::VW-1:0] op_b,
   output logic                       done,
   output logic signed [moi_pkg::VW-1:0] result
);
   import moi_pkg::*;

   localparam int NW = VW + FB;      // dividend / quotient width
   localparam int PW = 2 * VW;       // product width
   localparam int XW = PW + 1;       // width before saturation

   fx_state_type         state_ff, state_in;
   fx_op_type            op_ff;
   logic                 neg_ff, a_neg_ff, a_zero_ff;
   logic [VW-1:0]        ma_ff, mb_ff;
   logic [PW-1:0]        prod_ff;
   logic [VW-1:0]        rem_ff;
   logic [NW-1:0]        nq_ff;
   logic [6:0]           cnt_ff;
   logic                 done_ff;
   logic signed [VW-1:0] result_ff;

   logic [VW-1:0]        ma, mb;
   logic                 is_div, last;
   logic [VW:0]          psum, dtry;
   logic [XW-1:0]        prnd, mval, dval;
   logic signed [VW-1:0] fin;

   // Saturate a magnitude to the signed range and apply the sign
   function automatic logic signed [VW-1:0] sat_mag(input logic neg, input logic [XW-1:0] v);
      logic [XW-1:0] lim, c;
      lim = neg ? XW'(VMAX) + XW'(1) : XW'(VMAX);
      c   = (v > lim) ? lim : v;
      return neg ? -c[VW-1:0] : c[VW-1:0];
   endfunction

   assign ma     = op_a[VW-1] ? -op_a : op_a;
   assign mb     = op_b[VW-1] ? -op_b : op_b;
   assign is_div = (op_ff == FX_DIV) || (op_ff == FX_DIVRAW);
   assign last   = cnt_ff == (is_div ? 7'(NW - 1) : 7'(VW - 1));

   // One step of each iteration
   assign psum = {1'b0, prod_ff[PW-1:VW]} + (prod_ff[0] ? {1'b0, ma_ff} : '0);
   assign dtry = {rem_ff, nq_ff[NW-1]};

   // Final rounding
   assign prnd = {1'b0, prod_ff} + ((op_ff == FX_MULQ30) ? (XW'(1) << 29) : (XW'(1) << (FB - 1)));
   assign mval = (op_ff == FX_MULQ30) ? (prnd >> 30) : (prnd >> FB);
   assign dval = XW'(nq_ff) + XW'((op_ff == FX_DIV) && (rem_ff >= mb_ff - rem_ff));

   always_comb begin
      case (op_ff)
         FX_MULRAW: fin = VW'(prod_ff[PH_LSB +: PH_W]);
         FX_DIVRAW: fin = dval[VW-1:0];
         FX_DIV: begin
            if (mb_ff == '0) begin
               fin = a_neg_ff ? VMIN : (a_zero_ff ? '0 : VMAX);
            end else begin
               fin = sat_mag(neg_ff, dval);
            end
         end
         default:   fin = sat_mag(neg_ff, mval);
      endcase
   end

   // Control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FXS_IDLE: if (ctrl.start) state_in = FXS_RUN;
         FXS_RUN:  if (last) state_in = FXS_FIN;
         FXS_FIN:  state_in = FXS_IDLE;
         default:  state_in = FXS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FXS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= state_ff == FXS_FIN;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         FXS_IDLE: begin
            op_ff     <= ctrl.op;
            neg_ff    <= op_a[VW-1] ^ op_b[VW-1];
            a_neg_ff  <= op_a[VW-1];
            a_zero_ff <= op_a == '0;
            ma_ff     <= ma;
            mb_ff     <= mb;
            prod_ff   <= {{VW{1'b0}}, mb};
            rem_ff    <= '0;
            nq_ff     <= (ctrl.op == FX_DIVRAW) ? NW'(ma) : {ma, {FB{1'b0}}};
            cnt_ff    <= '0;
         end
         FXS_RUN: begin
            cnt_ff <= cnt_ff + 7'd1;
            if (is_div) begin
               if (dtry >= {1'b0, mb_ff}) begin
                  rem_ff <= VW'(dtry - {1'b0, mb_ff});
                  nq_ff  <= {nq_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= dtry[VW-1:0];
                  nq_ff  <= {nq_ff[NW-2:0], 1'b0};
               end
            end else begin
               prod_ff <= {psum, prod_ff[VW-1:1]};
            end
         end
         FXS_FIN: result_ff <= fin;
         default: ;
      endcase
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire
